/* hdl/psm_pkg.sv */
// ----------------------------------------------------------------------------
// psm_pkg: shared definitions for the pulse speed meter
// Ring sizing, register defaults, divider constants, sequencer states and
// the control structs exchanged with the serial divider.
// ----------------------------------------------------------------------------
package psm_pkg;

    // The averaging rings hold 2**AVG_LOG2 entries, so the averages are shifts.
    localparam int AVG_LOG2  = 3;
    localparam int AVG_DEPTH = 1 << AVG_LOG2;
    localparam int IDX_W     = (AVG_LOG2 > 0) ? AVG_LOG2 : 1;

    localparam int RPM_W      = 16;
    localparam int SPD_W      = 32;
    localparam int RPM_SUM_W  = RPM_W + AVG_LOG2;
    localparam int SPD_SUM_W  = SPD_W + AVG_LOG2;
    // Speed total is divided by 2 * AVG_DEPTH * 65536.
    localparam int TENTHS_SHIFT = AVG_LOG2 + 17;

    localparam int TIME_W = 32;
    localparam int DEN_W  = 40;
    localparam int QUOT_W = 26;
    localparam int DIV_CNT_W = $clog2(QUOT_W + 1);

    localparam logic [DEN_W-1:0] RPM_NUMER = DEN_W'(60000000);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR   = 2'd3;

    localparam logic [19:0] DEBOUNCE_RST = 20'd1000;
    localparam logic [23:0] TIMEOUT_RST  = 24'd50000;
    localparam logic [7:0]  SLOTS_RST    = 8'd20;
    localparam logic [15:0] FACTOR_RST   = 16'd8277;

    // Input kinds carried on tuser.
    localparam logic FUNC_PULSE = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DEN,
        ST_DIVGO,
        ST_DIV,
        ST_RPM,
        ST_MUL,
        ST_SPEED
    } state_t;

    typedef struct packed {
        logic start;
    } div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

/* hdl/pulse_speed_meter_core.sv */
// ----------------------------------------------------------------------------
// pulse_speed_meter_core: wheel speed from slotted-disc pulse periods
// Debounces sensor pulses, turns the pulse period into rpm, averages rpm and
// speed over two rings and reports zero speed after an idle timeout.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one event per transfer: tuser says whether it is
//   a sensor rising edge or a time check, tdata holds the microsecond time.
//   The output stream carries at most one result per event: tdata holds the
//   speed in tenths of km/h and the averaged rpm, tuser flags a timeout report.
//   Events that produce nothing (a bounced pulse, a time check before the
//   timeout) simply disappear.
//   The configuration channel is always ready and may be written only while
//   the block is idle.
//   An accepted pulse passes the check, denominator, divider start, the
//   bit-serial rpm divider, rpm and multiply steps to the speed step; a timeout
//   report goes from the check straight to the speed step. A new event is
//   taken once the previous one has left the sequencer.
//   The result sits in an output register, so the block takes the next event
//   while the receiver stalls; only a second result waits for the slot.
//   Reset clears both rings, sums, timestamps and the ring index at once and
//   restores the register defaults.
// ----------------------------------------------------------------------------
module pulse_speed_meter_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,   // [31:0] time_us
    input  logic [0:0]                        s_axis_tuser,   // [0] func
    // Output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,   // [15:0] speed_tenths,
                                                              // [31:16] rpm_avg
    output logic [0:0]                        m_axis_tuser,   // [0] from_timeout
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [psm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [psm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Configuration
    logic [19:0] debounce_reg;
    logic [23:0] timeout_reg;
    logic [7:0]  slots_reg;
    logic [15:0] factor_reg;

    // Sequencer
    psm_pkg::state_t state_reg;
    psm_pkg::state_t state_next;

    // Persistent measurement state
    logic [psm_pkg::TIME_W-1:0]    last_valid_reg;
    logic [psm_pkg::TIME_W-1:0]    last_emit_reg;
    logic [psm_pkg::RPM_W-1:0]     rpm_ring_reg [psm_pkg::AVG_DEPTH];
    logic [psm_pkg::SPD_W-1:0]     spd_ring_reg [psm_pkg::AVG_DEPTH];
    logic [psm_pkg::IDX_W-1:0]     idx_reg;
    logic [psm_pkg::IDX_W-1:0]     idx_next;
    logic [psm_pkg::RPM_SUM_W-1:0] rpm_sum_reg;
    logic [psm_pkg::RPM_SUM_W-1:0] rpm_sum_next;
    logic [psm_pkg::SPD_SUM_W-1:0] spd_sum_reg;
    logic [psm_pkg::SPD_SUM_W-1:0] spd_sum_next;

    // Per-event working registers
    logic [psm_pkg::TIME_W-1:0] time_reg;
    logic                       func_reg;
    logic [psm_pkg::TIME_W-1:0] diff_reg;
    logic [psm_pkg::DEN_W-1:0]  den_reg;
    logic [psm_pkg::RPM_W-1:0]  avg_reg;
    logic [psm_pkg::SPD_W-1:0]  sample_reg;
    logic                       tout_reg;

    // Output slot
    logic        out_valid_reg;
    logic [15:0] out_speed_reg;
    logic [15:0] out_rpm_reg;
    logic        out_tout_reg;

    // Combinational helpers
    logic [psm_pkg::TIME_W-1:0] diff_valid;
    logic [psm_pkg::TIME_W-1:0] diff_emit;
    logic                       pulse_ok;
    logic                       timeout_hit;
    logic [7:0]                 slots_eff;
    logic [psm_pkg::DEN_W-1:0]  den_next;
    logic [psm_pkg::QUOT_W-1:0] quot;
    logic [psm_pkg::RPM_W-1:0]  raw_rpm;
    logic [15:0]                tenths;

    logic in_take;
    logic zero_load;
    logic rpm_load;
    logic spd_load;

    psm_pkg::div_cmd_t div_cmd;
    psm_pkg::div_sts_t div_sts;

    psm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .den   (den_reg),
        .sts   (div_sts),
        .quot  (quot)
    );

    assign diff_valid  = time_reg - last_valid_reg;
    assign diff_emit   = time_reg - last_emit_reg;
    assign pulse_ok    = (diff_valid != '0) && (diff_valid >= {12'b0, debounce_reg});
    assign timeout_hit = (diff_valid > {8'b0, timeout_reg}) &&
                         (diff_emit > {8'b0, timeout_reg});
    assign slots_eff   = (slots_reg == '0) ? 8'd1 : slots_reg;
    assign den_next    = psm_pkg::DEN_W'(diff_reg) * psm_pkg::DEN_W'(slots_eff);

    assign raw_rpm = (quot[psm_pkg::QUOT_W-1:psm_pkg::RPM_W] != '0) ?
                     {psm_pkg::RPM_W{1'b1}} : quot[psm_pkg::RPM_W-1:0];

    assign rpm_sum_next = rpm_sum_reg
                        - psm_pkg::RPM_SUM_W'(rpm_ring_reg[idx_reg])
                        + psm_pkg::RPM_SUM_W'(raw_rpm);
    assign spd_sum_next = spd_sum_reg
                        - psm_pkg::SPD_SUM_W'(spd_ring_reg[idx_reg])
                        + psm_pkg::SPD_SUM_W'(sample_reg);
    // The shifted speed total always fits in 15 bits, so no saturation is needed.
    assign tenths = 16'(spd_sum_next[psm_pkg::SPD_SUM_W-1:psm_pkg::TENTHS_SHIFT]);

    assign idx_next = (idx_reg == psm_pkg::IDX_W'(psm_pkg::AVG_DEPTH - 1)) ?
                      '0 : idx_reg + 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        in_take       = 1'b0;
        zero_load     = 1'b0;
        rpm_load      = 1'b0;
        spd_load      = 1'b0;
        div_cmd.start = 1'b0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            psm_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    in_take    = 1'b1;
                    state_next = psm_pkg::ST_CHECK;
                end
            end
            psm_pkg::ST_CHECK:
            begin
                if (func_reg == psm_pkg::FUNC_PULSE)
                begin
                    state_next = pulse_ok ? psm_pkg::ST_DEN : psm_pkg::ST_IDLE;
                end
                else if (timeout_hit)
                begin
                    zero_load  = 1'b1;
                    state_next = psm_pkg::ST_SPEED;
                end
                else
                begin
                    state_next = psm_pkg::ST_IDLE;
                end
            end
            psm_pkg::ST_DEN:
            begin
                state_next = psm_pkg::ST_DIVGO;
            end
            psm_pkg::ST_DIVGO:
            begin
                div_cmd.start = 1'b1;
                state_next    = psm_pkg::ST_DIV;
            end
            psm_pkg::ST_DIV:
            begin
                if (div_sts.done)
                begin
                    state_next = psm_pkg::ST_RPM;
                end
            end
            psm_pkg::ST_RPM:
            begin
                rpm_load   = 1'b1;
                state_next = psm_pkg::ST_MUL;
            end
            psm_pkg::ST_MUL:
            begin
                state_next = psm_pkg::ST_SPEED;
            end
            psm_pkg::ST_SPEED:
            begin
                // Wait here only while an earlier result still occupies the slot.
                if (!out_valid_reg || m_axis_tready)
                begin
                    spd_load   = 1'b1;
                    state_next = psm_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= psm_pkg::DEBOUNCE_RST;
            timeout_reg  <= psm_pkg::TIMEOUT_RST;
            slots_reg    <= psm_pkg::SLOTS_RST;
            factor_reg   <= psm_pkg::FACTOR_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                psm_pkg::CFG_DEBOUNCE: debounce_reg <= cfg_data[19:0];
                psm_pkg::CFG_TIMEOUT:  timeout_reg  <= cfg_data[23:0];
                psm_pkg::CFG_SLOTS:    slots_reg    <= cfg_data[7:0];
                psm_pkg::CFG_FACTOR:   factor_reg   <= cfg_data[15:0];
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Measurement state, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_valid_reg <= '0;
            last_emit_reg  <= '0;
            idx_reg        <= '0;
            rpm_sum_reg    <= '0;
            spd_sum_reg    <= '0;
            for (int i = 0; i < psm_pkg::AVG_DEPTH; i++)
            begin
                rpm_ring_reg[i] <= '0;
                spd_ring_reg[i] <= '0;
            end
        end
        else
        begin
            if (rpm_load)
            begin
                rpm_sum_reg           <= rpm_sum_next;
                rpm_ring_reg[idx_reg] <= raw_rpm;
            end
            if (spd_load)
            begin
                spd_sum_reg           <= spd_sum_next;
                spd_ring_reg[idx_reg] <= sample_reg;
                idx_reg               <= idx_next;
                last_emit_reg         <= time_reg;
                if (func_reg == psm_pkg::FUNC_PULSE)
                begin
                    last_valid_reg <= time_reg;
                end
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            time_reg <= s_axis_tdata;
            func_reg <= s_axis_tuser[0];
        end
        if (state_reg == psm_pkg::ST_CHECK)
        begin
            diff_reg <= diff_valid;
        end
        if (state_reg == psm_pkg::ST_DEN)
        begin
            den_reg <= den_next;
        end
        if (zero_load)
        begin
            avg_reg    <= '0;
            sample_reg <= '0;
            tout_reg   <= 1'b1;
        end
        else if (rpm_load)
        begin
            avg_reg  <= rpm_sum_next[psm_pkg::RPM_SUM_W-1:psm_pkg::AVG_LOG2];
            tout_reg <= 1'b0;
        end
        if (state_reg == psm_pkg::ST_MUL)
        begin
            sample_reg <= psm_pkg::SPD_W'(avg_reg) * psm_pkg::SPD_W'(factor_reg);
        end
        if (spd_load)
        begin
            // A timeout report carries zero speed whatever the ring average is.
            out_speed_reg <= tout_reg ? 16'd0 : tenths;
            out_rpm_reg   <= avg_reg;
            out_tout_reg  <= tout_reg;
        end
    end

    // Output slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (spd_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_rpm_reg, out_speed_reg};
    assign m_axis_tuser  = out_tout_reg;

    // A timeout report always carries zero speed and zero rpm.
    a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("timeout report with nonzero data");

    // A new result appears only when the sequencer finishes an event.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == psm_pkg::ST_SPEED))
        else $error("result appeared outside the final step");

    // The sequencer never waits on an idle divider.
    a_div_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == psm_pkg::ST_DIV) |-> (div_sts.busy || div_sts.done))
        else $error("waiting on an idle divider");

    // The shared ring position stays inside the rings.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= psm_pkg::IDX_W'(psm_pkg::AVG_DEPTH - 1))
        else $error("ring index out of range");

endmodule

/* hdl/psm_div.sv */
// ----------------------------------------------------------------------------
// psm_div: bit-serial rounded rpm divider
// Computes (60000000 + den/2) / den one quotient bit per cycle with a
// restoring shift-subtract loop over QUOT_W quotient bits.
// ----------------------------------------------------------------------------
module psm_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  psm_pkg::div_cmd_t                 cmd,
    input  logic [psm_pkg::DEN_W-1:0]         den,
    output psm_pkg::div_sts_t                 sts,
    output logic [psm_pkg::QUOT_W-1:0]        quot
);

    logic [psm_pkg::DEN_W-1:0]     rem_reg;
    logic [psm_pkg::DEN_W-1:0]     rem_next;
    logic [psm_pkg::QUOT_W-1:0]    q_reg;
    logic [psm_pkg::QUOT_W-1:0]    q_next;
    logic [psm_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [psm_pkg::DIV_CNT_W-1:0] cnt_next;
    logic                          done_reg;
    logic                          done_next;

    logic [psm_pkg::DEN_W-1:0]     numer;
    logic [psm_pkg::DEN_W:0]       shifted;
    logic [psm_pkg::DEN_W:0]       trial;

    // The quotient never exceeds QUOT_W bits, so the upper numerator bits
    // already form a partial remainder below den.
    assign numer   = psm_pkg::RPM_NUMER + {1'b0, den[psm_pkg::DEN_W-1:1]};
    assign shifted = {rem_reg, q_reg[psm_pkg::QUOT_W-1]};
    assign trial   = shifted - {1'b0, den};

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            rem_next = psm_pkg::DEN_W'(numer >> psm_pkg::QUOT_W);
            q_next   = numer[psm_pkg::QUOT_W-1:0];
            cnt_next = psm_pkg::DIV_CNT_W'(psm_pkg::QUOT_W);
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[psm_pkg::DEN_W])
            begin
                rem_next = trial[psm_pkg::DEN_W-1:0];
                q_next   = {q_reg[psm_pkg::QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[psm_pkg::DEN_W-1:0];
                q_next   = {q_reg[psm_pkg::QUOT_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == psm_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign sts.busy = (cnt_reg != '0);
    assign sts.done = done_reg;
    assign quot     = q_reg;

endmodule
